>>> rtl/core/uer_pkg.sv
// Shared types, constants and register map of the ultrasonic echo ranger.
package uer_pkg;

    // Width of the microsecond timer
    localparam int TIMER_BITS = 17;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Divider: dividend is ten times the timer value, which needs four more bits
    localparam int DIV_W     = TIMER_BITS + 4;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    // Common width for compares against 16-bit registers
    localparam int CMP_W = (DIV_W > 16) ? DIV_W : 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LOW_US  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH_US = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT_US = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_DIVISOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE_MM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_MM    = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_CLOCKS_PER_US   = 8'd72;
    localparam logic [7:0]  RST_TRIGGER_LOW_US  = 8'd2;
    localparam logic [7:0]  RST_TRIGGER_HIGH_US = 8'd10;
    localparam logic [15:0] RST_ECHO_TIMEOUT_US = 16'd30000;
    localparam logic [7:0]  RST_SOUND_DIVISOR   = 8'd58;
    localparam logic [15:0] RST_MIN_RANGE_MM    = 16'd20;
    localparam logic [15:0] RST_MAX_RANGE_MM    = 16'd4000;

    // Distance reported after a timeout
    localparam logic [15:0] TIMEOUT_CODE = 16'hFFFF;

    // Input transaction
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } uer_in_t;

    // Result transaction
    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic        ok;
        logic [15:0] range_mm;
    } uer_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_cnt;
        logic tick;
        logic div_start;
        logic div_step;
        logic res_timeout;
        logic res_ok;
        logic out_load;
        logic out_trig;
        logic out_busy;
        logic out_done;
    } uer_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic low_reached;
        logic high_reached;
        logic timed_out;
        logic div_last;
        logic out_free;
    } uer_sts_t;

endpackage

>>> rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: controller plus datapath.
//
//  channel | signals                          | role
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid, in_ready, in_data      | start request and echo sample
//  out     | out_valid, out_ready, out_data   | one result transaction per input
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait, no read-back
//
// Every input transaction but the one that sees the echo fall loads its result directly;
// that one runs the serial divider, one quotient bit per cycle (TIMER_BITS + 4 steps),
// then clamps and loads it in S_FIN once the output is free, with in_ready low throughout.
// The output register lets a new transaction in while the last result is taken.
// A stalled output holds in_ready low. Reset loads the register defaults, idle phase.
module ultrasonic_echo_ranger import uer_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  uer_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uer_out_t              out_data
);

    uer_cmd_t cmd;
    uer_sts_t sts;

    // Phase sequencer
    uer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Timer, divider and result storage
    uer_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/uer_dp.sv
// Datapath: config registers, microsecond timer, serial divider, result and output registers.
module uer_dp import uer_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  uer_cmd_t              cmd,
    output uer_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uer_out_t              out_data
);

    // Configuration registers
    logic [7:0]  clocks_per_us_reg,   clocks_per_us_next;
    logic [7:0]  trigger_low_us_reg,  trigger_low_us_next;
    logic [7:0]  trigger_high_us_reg, trigger_high_us_next;
    logic [15:0] echo_timeout_us_reg, echo_timeout_us_next;
    logic [7:0]  sound_divisor_reg,   sound_divisor_next;
    logic [15:0] min_range_mm_reg,    min_range_mm_next;
    logic [15:0] max_range_mm_reg,    max_range_mm_next;

    // Timer, divider, results, output
    logic [7:0]            prescale_reg,  prescale_next;
    logic [TIMER_BITS-1:0] elapsed_reg,   elapsed_next;
    logic [DIV_W-1:0]      quo_reg,       quo_next;
    logic [7:0]            rem_reg,       rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg,   div_cnt_next;
    logic [15:0]           last_dist_reg, last_dist_next;
    logic                  last_ok_reg,   last_ok_next;
    logic                  out_valid_reg, out_valid_next;
    uer_out_t              out_data_reg,  out_data_next;

    logic [7:0]            cpu_eff;
    logic [7:0]            div_eff;
    logic [7:0]            pres_inc;
    logic                  us_wrap;
    logic [7:0]            pres_tick;
    logic [TIMER_BITS-1:0] el_tick;
    logic [CMP_W-1:0]      el_cmp;
    logic [DIV_W-1:0]      dividend;
    logic [8:0]            rem_sh;
    logic                  rem_ge;
    logic [7:0]            rem_sub;
    logic [CMP_W-1:0]      quo_cmp;
    logic [CMP_W-1:0]      min_cmp;
    logic [CMP_W-1:0]      max_cmp;
    logic [CMP_W-1:0]      clamped;

    // Config write decode
    always_comb
    begin
        clocks_per_us_next   = clocks_per_us_reg;
        trigger_low_us_next  = trigger_low_us_reg;
        trigger_high_us_next = trigger_high_us_reg;
        echo_timeout_us_next = echo_timeout_us_reg;
        sound_divisor_next   = sound_divisor_reg;
        min_range_mm_next    = min_range_mm_reg;
        max_range_mm_next    = max_range_mm_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLOCKS_PER_US:   clocks_per_us_next   = cfg_data[7:0];
                REG_TRIGGER_LOW_US:  trigger_low_us_next  = cfg_data[7:0];
                REG_TRIGGER_HIGH_US: trigger_high_us_next = cfg_data[7:0];
                REG_ECHO_TIMEOUT_US: echo_timeout_us_next = cfg_data;
                REG_SOUND_DIVISOR:   sound_divisor_next   = cfg_data[7:0];
                REG_MIN_RANGE_MM:    min_range_mm_next    = cfg_data;
                REG_MAX_RANGE_MM:    max_range_mm_next    = cfg_data;
                default: ;
            endcase
        end
    end

    // Prescaler and saturating microsecond counter, value after one tick
    always_comb
    begin
        cpu_eff   = (clocks_per_us_reg == 8'd0) ? 8'd1 : clocks_per_us_reg;
        pres_inc  = prescale_reg + 8'd1;
        us_wrap   = (pres_inc >= cpu_eff);
        pres_tick = us_wrap ? 8'd0 : pres_inc;
        el_tick   = elapsed_reg;
        if (us_wrap && (elapsed_reg != TIMER_MAX))
            el_tick = elapsed_reg + TIMER_BITS'(1);
        el_cmp = CMP_W'(el_tick);
    end

    // Phase-end tests on the ticked timer
    assign sts.low_reached  = (el_cmp >= CMP_W'(trigger_low_us_reg));
    assign sts.high_reached = (el_cmp >= CMP_W'(trigger_high_us_reg));
    assign sts.timed_out    = (el_cmp > CMP_W'(echo_timeout_us_reg)) || (el_tick == TIMER_MAX);
    assign sts.div_last     = (div_cnt_reg == DIV_LAST);
    assign sts.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        prescale_next = prescale_reg;
        elapsed_next  = elapsed_reg;
        if (cmd.clr_cnt)
        begin
            prescale_next = 8'd0;
            elapsed_next  = '0;
        end
        else if (cmd.tick)
        begin
            prescale_next = pres_tick;
            elapsed_next  = el_tick;
        end
    end

    // Restoring divider, one quotient bit per step: 10 * us / divisor
    always_comb
    begin
        div_eff  = (sound_divisor_reg == 8'd0) ? 8'd1 : sound_divisor_reg;
        dividend = (DIV_W'(elapsed_reg) << 3) + (DIV_W'(elapsed_reg) << 1);
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        rem_ge   = (rem_sh >= {1'b0, div_eff});
        rem_sub  = 8'(rem_sh - {1'b0, div_eff});
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            quo_next     = dividend;
            rem_next     = 8'd0;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next     = {quo_reg[DIV_W-2:0], rem_ge};
            rem_next     = rem_ge ? rem_sub : rem_sh[7:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Clamp; the minimum is tested first, so it wins only for values below it
    always_comb
    begin
        quo_cmp = CMP_W'(quo_reg);
        min_cmp = CMP_W'(min_range_mm_reg);
        max_cmp = CMP_W'(max_range_mm_reg);
        if (quo_cmp < min_cmp)
            clamped = min_cmp;
        else if (quo_cmp > max_cmp)
            clamped = max_cmp;
        else
            clamped = quo_cmp;
    end

    // Result registers and output stage
    always_comb
    begin
        last_dist_next = last_dist_reg;
        last_ok_next   = last_ok_reg;
        if (cmd.res_timeout)
        begin
            last_dist_next = TIMEOUT_CODE;
            last_ok_next   = 1'b0;
        end
        else if (cmd.res_ok)
        begin
            last_dist_next = clamped[15:0];
            last_ok_next   = 1'b1;
        end

        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.trigger_level = cmd.out_trig;
            out_data_next.busy_res      = cmd.out_busy;
            out_data_next.done_res      = cmd.out_done;
            out_data_next.ok            = last_ok_next;
            out_data_next.range_mm      = last_dist_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clocks_per_us_reg   <= RST_CLOCKS_PER_US;
            trigger_low_us_reg  <= RST_TRIGGER_LOW_US;
            trigger_high_us_reg <= RST_TRIGGER_HIGH_US;
            echo_timeout_us_reg <= RST_ECHO_TIMEOUT_US;
            sound_divisor_reg   <= RST_SOUND_DIVISOR;
            min_range_mm_reg    <= RST_MIN_RANGE_MM;
            max_range_mm_reg    <= RST_MAX_RANGE_MM;
            prescale_reg        <= 8'd0;
            elapsed_reg         <= '0;
            div_cnt_reg         <= '0;
            last_dist_reg       <= 16'd0;
            last_ok_reg         <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            clocks_per_us_reg   <= clocks_per_us_next;
            trigger_low_us_reg  <= trigger_low_us_next;
            trigger_high_us_reg <= trigger_high_us_next;
            echo_timeout_us_reg <= echo_timeout_us_next;
            sound_divisor_reg   <= sound_divisor_next;
            min_range_mm_reg    <= min_range_mm_next;
            max_range_mm_reg    <= max_range_mm_next;
            prescale_reg        <= prescale_next;
            elapsed_reg         <= elapsed_next;
            div_cnt_reg         <= div_cnt_next;
            last_dist_reg       <= last_dist_next;
            last_ok_reg         <= last_ok_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_timeout_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_timeout |=> (last_dist_reg == TIMEOUT_CODE) && !last_ok_reg)
        else $error("timeout did not record the timeout code");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_cnt |=> (elapsed_reg == '0) && (prescale_reg == 8'd0))
        else $error("counters not cleared on phase change");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && (out_data_reg.ok == last_ok_reg))
        else $error("output register not loaded with current result");

endmodule

>>> rtl/core/uer_ctrl.sv
// Controller: measurement phase sequencer and divider sequencing.
module uer_ctrl import uer_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  uer_in_t  in_data,
    input  uer_sts_t sts,
    output uer_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TLOW,
        S_THIGH,
        S_RISE,
        S_FALL,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    // A transaction is taken only outside S_DIV and S_FIN, with room at the output
    assign in_ready = (state_reg != S_DIV) && (state_reg != S_FIN) && sts.out_free;
    assign take     = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.out_load = 1'b1;
                    if (in_data.start_req)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_TLOW;
                    end
                end
            end
            S_TLOW:
            begin
                if (take)
                begin
                    cmd.out_load = 1'b1;
                    cmd.tick     = 1'b1;
                    if (sts.low_reached)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_THIGH;
                    end
                end
            end
            S_THIGH:
            begin
                if (take)
                begin
                    cmd.out_load = 1'b1;
                    cmd.tick     = 1'b1;
                    if (sts.high_reached)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_RISE;
                    end
                end
            end
            S_RISE:
            begin
                if (take)
                begin
                    cmd.out_load = 1'b1;
                    if (in_data.echo_level)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_FALL;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                        if (sts.timed_out)
                        begin
                            cmd.res_timeout = 1'b1;
                            cmd.out_done    = 1'b1;
                            cmd.clr_cnt     = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                end
            end
            S_FALL:
            begin
                if (take)
                begin
                    if (!in_data.echo_level)
                    begin
                        // echo ended: scale the width, result goes out after the divide
                        cmd.div_start = 1'b1;
                        cmd.clr_cnt   = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.tick     = 1'b1;
                        if (sts.timed_out)
                        begin
                            cmd.res_timeout = 1'b1;
                            cmd.out_done    = 1'b1;
                            cmd.clr_cnt     = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_ok   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.out_trig = (state_next == S_THIGH);
        cmd.out_busy = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output loaded while a result is still pending");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_done) |-> (!cmd.out_busy && !cmd.out_trig))
        else $error("done reported with measurement still running");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> $past(state_reg == S_DIV) || $past(state_reg == S_FIN))
        else $error("finish entered without a divide");

endmodule

>>> verif/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for the ultrasonic echo ranger top level.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam int HOLD_CYCLES   = 400;            // long output stall for back-pressure
    localparam int SETTLE_CYCLES = TIMER_BITS + 10; // divider plus clamp, with margin
    localparam int RUN_LIMIT_NS  = 100_000_000;     // in ns, far above a clean run
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_WAIT_FALL = 3'd4
    } ranger_phase_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    uer_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    uer_out_t              out_data;

    // Traffic shaping
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    // Bookkeeping
    uer_out_t pending_results[$];
    int       samples_sent  = 0;
    int       result_errors = 0;

    // Register copies
    logic [7:0]  rg_clocks_per_us;
    logic [7:0]  rg_trig_low;
    logic [7:0]  rg_trig_high;
    logic [15:0] rg_echo_timeout;
    logic [7:0]  rg_sound_div;
    logic [15:0] rg_min_mm;
    logic [15:0] rg_max_mm;

    // Ranger state copies
    ranger_phase_t         ph;
    logic [7:0]            pre_cnt;
    logic [TIMER_BITS-1:0] us_cnt;
    logic [15:0]           last_mm;
    logic                  last_ok;

    ultrasonic_echo_ranger u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Ranger prediction
    // ------------------------------------------------------------------
    function automatic void clear_timer();
        pre_cnt = '0;
        us_cnt  = '0;
    endfunction

    // One tick of the microsecond prescaler; timer saturates
    function automatic void step_timer();
        logic [7:0] cpu;
        cpu = (rg_clocks_per_us == 8'd0) ? 8'd1 : rg_clocks_per_us;
        pre_cnt = pre_cnt + 8'd1;
        if (pre_cnt >= cpu)
        begin
            pre_cnt = '0;
            if (us_cnt != TIMER_MAX)
                us_cnt = us_cnt + 1'b1;
        end
    endfunction

    function automatic logic echo_expired();
        return (32'(us_cnt) > 32'(rg_echo_timeout)) || (us_cnt == TIMER_MAX);
    endfunction

    function automatic void end_with_timeout();
        last_mm = TIMEOUT_CODE;
        last_ok = 1'b0;
        ph      = PH_IDLE;
        clear_timer();
    endfunction

    // Advance the ranger by one accepted sample, return the expected result
    function automatic uer_out_t predict_ranging(input uer_in_t smp);
        uer_out_t   r;
        logic       done;
        logic [31:0] prod;
        logic [31:0] dv;
        logic [31:0] mm;
        done = 1'b0;
        case (ph)
            PH_IDLE:
            begin
                if (smp.start_req)
                begin
                    ph = PH_TRIG_LOW;
                    clear_timer();
                end
            end
            PH_TRIG_LOW:
            begin
                step_timer();
                if (32'(us_cnt) >= 32'(rg_trig_low))
                begin
                    ph = PH_TRIG_HIGH;
                    clear_timer();
                end
            end
            PH_TRIG_HIGH:
            begin
                step_timer();
                if (32'(us_cnt) >= 32'(rg_trig_high))
                begin
                    ph = PH_WAIT_RISE;
                    clear_timer();
                end
            end
            PH_WAIT_RISE:
            begin
                if (smp.echo_level)
                begin
                    ph = PH_WAIT_FALL;
                    clear_timer();
                end
                else
                begin
                    step_timer();
                    if (echo_expired())
                    begin
                        end_with_timeout();
                        done = 1'b1;
                    end
                end
            end
            PH_WAIT_FALL:
            begin
                if (!smp.echo_level)
                begin
                    // width * 10 / divisor, clamped with the minimum tested first
                    prod = 32'(us_cnt) * 32'd10;
                    dv   = (rg_sound_div == 8'd0) ? 32'd1 : 32'(rg_sound_div);
                    mm   = prod / dv;
                    if (mm < 32'(rg_min_mm))
                        mm = 32'(rg_min_mm);
                    else if (mm > 32'(rg_max_mm))
                        mm = 32'(rg_max_mm);
                    last_mm = mm[15:0];
                    last_ok = 1'b1;
                    done    = 1'b1;
                    ph      = PH_IDLE;
                    clear_timer();
                end
                else
                begin
                    step_timer();
                    if (echo_expired())
                    begin
                        end_with_timeout();
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                ph = PH_IDLE;
                clear_timer();
            end
        endcase
        r.trigger_level = (ph == PH_TRIG_HIGH);
        r.busy_res      = (ph != PH_IDLE);
        r.done_res      = done;
        r.ok            = last_ok;
        r.range_mm      = last_mm;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_CLOCKS_PER_US:   rg_clocks_per_us = data[7:0];
            REG_TRIGGER_LOW_US:  rg_trig_low      = data[7:0];
            REG_TRIGGER_HIGH_US: rg_trig_high     = data[7:0];
            REG_ECHO_TIMEOUT_US: rg_echo_timeout  = data;
            REG_SOUND_DIVISOR:   rg_sound_div     = data[7:0];
            REG_MIN_RANGE_MM:    rg_min_mm        = data;
            REG_MAX_RANGE_MM:    rg_max_mm        = data;
            default: ;
        endcase
    endtask

    // Write all seven registers back to back; 8-bit ones get junk in the upper byte
    task automatic load_regs(input logic [7:0] cpu, input logic [7:0] tl, input logic [7:0] th,
                             input logic [15:0] tmo, input logic [7:0] dv,
                             input logic [15:0] mn, input logic [15:0] mx);
        write_reg(REG_CLOCKS_PER_US,   {8'($urandom), cpu});
        write_reg(REG_TRIGGER_LOW_US,  {8'($urandom), tl});
        write_reg(REG_TRIGGER_HIGH_US, {8'($urandom), th});
        write_reg(REG_ECHO_TIMEOUT_US, tmo);
        write_reg(REG_SOUND_DIVISOR,   {8'($urandom), dv});
        write_reg(REG_MIN_RANGE_MM,    mn);
        write_reg(REG_MAX_RANGE_MM,    mx);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_sample(input logic start, input logic echo);
        uer_in_t smp;
        smp.start_req  = start;
        smp.echo_level = echo;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_ranging(smp));
        samples_sent++;
    endtask

    // One measurement: start, ride out the trigger, echo low then high then low
    task automatic run_measurement(input int rise_len, input int high_len);
        int n;
        send_sample(1'b1, 1'($urandom_range(1)));
        // starts during the trigger are ignored, echo is don't-care
        while (ph == PH_TRIG_LOW || ph == PH_TRIG_HIGH)
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
        n = 0;
        while (ph == PH_WAIT_RISE && n < rise_len)
        begin
            send_sample(1'($urandom_range(1)), 1'b0);
            n++;
        end
        if (ph == PH_WAIT_RISE)
            send_sample(1'($urandom_range(1)), 1'b1);
        n = 0;
        while (ph == PH_WAIT_FALL && n < high_len)
        begin
            send_sample(1'($urandom_range(1)), 1'b1);
            n++;
        end
        if (ph == PH_WAIT_FALL)
            send_sample(1'($urandom_range(1)), 1'b0);
    endtask

    // Bring the ranger to idle and wait for every result before touching registers
    task automatic quiesce();
        while (ph != PH_IDLE)
            send_sample(1'b0, 1'b0);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready generation with optional long hold
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Result checker
    uer_out_t exp_r;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (result_errors < MAX_REPORTS)
                    $display("unexpected result transaction: %p", out_data);
                result_errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_data.trigger_level !== exp_r.trigger_level ||
                    out_data.busy_res      !== exp_r.busy_res ||
                    out_data.done_res      !== exp_r.done_res ||
                    out_data.ok            !== exp_r.ok ||
                    out_data.range_mm      !== exp_r.range_mm)
                begin
                    if (result_errors < MAX_REPORTS)
                        $display("mismatch: exp %p | got %p", exp_r, out_data);
                    result_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state and reset register values; only the prescaler is shortened
    task automatic test_reset_values();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (3) send_sample(1'b0, 1'($urandom_range(1)));
        quiesce();
        write_reg(REG_CLOCKS_PER_US, 16'd1);
        cfg_we <= 1'b0;
        run_measurement(3, 3);      // short echo, clamped to the default minimum
        run_measurement(2, 130);    // inside the default limits
        quiesce();
    endtask

    // Zero prescaler and divisor, zero low time, both timeouts, inverted clamp,
    // stray register index, starts while busy
    task automatic test_special_cases();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(REG_UNUSED, 16'($urandom));
        load_regs(8'd0, 8'd0, 8'd1, 16'd2, 8'd0, 16'd0, 16'hFFFF);
        run_measurement(10, 0);   // echo never rises
        run_measurement(0, 5);    // echo stuck high
        quiesce();
        load_regs(8'd0, 8'd0, 8'd1, 16'd20, 8'd0, 16'd15, 16'd10);
        run_measurement(0, 0);    // zero width, below the minimum
        run_measurement(0, 2);    // above the maximum
        quiesce();
    endtask

    // Register extremes
    task automatic test_extreme_settings();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // slowest prescaler and largest divisor
        load_regs(8'd255, 8'd0, 8'd1, 16'd1, 8'd255, 16'd0, 16'hFFFF);
        run_measurement(0, 0);
        quiesce();
        // fastest prescaler, longest timeout, limits crossed at full range
        load_regs(8'd1, 8'd0, 8'd1, 16'hFFFF, 8'd1, 16'hFFFF, 16'd0);
        run_measurement(5, 20);
        quiesce();
    endtask

    // Long output stall while the sender keeps pushing
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        load_regs(8'd1, 8'd1, 8'd2, 16'd40, 8'd3, 16'd0, 16'd1000);
        hold_reqs <= hold_reqs + 1;
        run_measurement(20, 25);
        quiesce();
    endtask

    // Randomized registers and measurement sequences with some noise
    task automatic run_random_round(input int target);
        logic [7:0]  cpu;
        logic [7:0]  tl;
        logic [7:0]  th;
        logic [15:0] tmo;
        logic [7:0]  dv;
        logic [15:0] mn;
        logic [15:0] mx;
        int          span;
        int          first;
        int          k;
        cpu  = 8'($urandom_range(3));
        tl   = 8'($urandom_range(4));
        th   = 8'($urandom_range(4));
        tmo  = 16'($urandom_range(12, 1));
        dv   = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(12));
        if ($urandom_range(1))
        begin
            mn = 16'($urandom_range(30));
            mx = 16'($urandom_range(300));
        end
        else
        begin
            mn = 16'($urandom);
            mx = 16'($urandom);
        end
        load_regs(cpu, tl, th, tmo, dv, mn, mx);
        span  = (int'(tmo) + 2) * ((cpu == 8'd0) ? 1 : int'(cpu));
        first = samples_sent;
        while (samples_sent - first < target)
        begin
            if ($urandom_range(99) < 85)
                run_measurement($urandom_range(span), $urandom_range(span));
            else
            begin
                k = $urandom_range(8, 1);
                repeat (k) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        quiesce();
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            run_random_round(45);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rg_clocks_per_us = RST_CLOCKS_PER_US;
        rg_trig_low      = RST_TRIGGER_LOW_US;
        rg_trig_high     = RST_TRIGGER_HIGH_US;
        rg_echo_timeout  = RST_ECHO_TIMEOUT_US;
        rg_sound_div     = RST_SOUND_DIVISOR;
        rg_min_mm        = RST_MIN_RANGE_MM;
        rg_max_mm        = RST_MAX_RANGE_MM;
        ph               = PH_IDLE;
        clear_timer();
        last_mm          = '0;
        last_ok          = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_special_cases();
        test_extreme_settings();
        test_output_backpressure();
        test_random_traffic();

        if (result_errors == 0 && pending_results.size() == 0)
            $display("[ultrasonic_echo_ranger] OK");
        else
            $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

endmodule
